// ===== rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, round constants and mixing functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    // Input transaction: one message byte or a finish request
    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } item_t;

    // Output transaction: one word of the digest
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_t;

    // Input modes
    localparam logic MODE_DATA   = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    // Block geometry
    localparam int BLOCK_BYTES = 64;
    localparam int LEN_START   = 56;
    localparam logic [7:0] PAD_MARKER = 8'h80;

    // Initial hash value
    localparam logic [31:0] IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants
    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Compression mixing functions
    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // Message schedule mixing functions, then the compression choose and majority
    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// ===== rtl/sha256_stream_hash.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hash
// SHA-256 over a byte stream: buffers bytes, pads on finish and returns the
// eight digest words, then restarts from the initial hash value.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake                    | Payload
//  item     | in        | item_valid / item_ready      | sha_pkg::item_t
//  digest   | out       | digest_valid / digest_ready  | sha_pkg::digest_t
//
//  A data byte is taken in idle; the byte that fills a block starts the
//  rounds and then the fold on the single shared round unit.
//  A finish writes padding bytes up to the block end, runs one or two
//  compressions, then hands out the eight digest words.
//  No new byte is taken while the round unit compresses a block.
//  Reset (rst_n, asynchronous) loads the initial hash and empties the buffer.
//  A stalled digest holds the output register and the emit state; item_ready
//  is high in idle even while the last digest word still waits.
// ----------------------------------------------------------------------------
module sha256_stream_hash
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  sha_pkg::item_t   item,
    output logic             digest_valid,
    input  logic             digest_ready,
    output sha_pkg::digest_t digest
);
    import sha_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    localparam logic [5:0] LAST_POS  = 6'(BLOCK_BYTES - 1);
    localparam logic [5:0] LEN_POS   = 6'(LEN_START);
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD = 3'd7;

    state_t        state_reg, state_next;
    logic [511:0]  blk_reg, blk_next;       // byte buffer, then schedule window
    logic [5:0]    fill_reg, fill_next;
    logic [60:0]   msg_reg, msg_next;
    logic [5:0]    round_reg, round_next;
    logic [2:0]    idx_reg, idx_next;
    logic          pad_reg, pad_next;       // finish in progress
    logic          mark_reg, mark_next;     // 0x80 marker placed
    logic          len_ok_reg, len_ok_next; // length goes into this block
    logic [31:0]   chain_reg [8];
    logic [31:0]   chain_next [8];
    logic [31:0]   v_reg [8];
    logic [31:0]   v_next [8];
    logic          dval_reg, dval_next;
    digest_t       dout_reg, dout_next;

    logic [31:0]   w0, w1, w9, w14, w_new, t1, t2;
    logic [63:0]   bit_len;
    logic [7:0]    len_byte, pad_byte;
    logic          out_free;

    // Schedule window taps and round arithmetic
    assign w0  = blk_reg[511:480];
    assign w1  = blk_reg[479:448];
    assign w9  = blk_reg[223:192];
    assign w14 = blk_reg[63:32];
    assign w_new = w0 + ssig0(w1) + w9 + ssig1(w14);
    assign t1 = v_reg[7] + bsig1(v_reg[4]) + choose(v_reg[4], v_reg[5], v_reg[6])
              + K_TABLE[round_reg] + w0;
    assign t2 = bsig0(v_reg[0]) + majority(v_reg[0], v_reg[1], v_reg[2]);

    // Padding byte: marker, zeros, then the big-endian bit length
    assign bit_len  = {msg_reg, 3'b000};
    assign len_byte = bit_len[{LAST_WORD - fill_reg[2:0], 3'b000} +: 8];
    assign pad_byte = !mark_reg ? PAD_MARKER :
                      (len_ok_reg && fill_reg >= LEN_POS) ? len_byte : 8'h00;

    assign out_free   = !dval_reg || digest_ready;
    assign item_ready = (state_reg == ST_IDLE);
    assign digest_valid = dval_reg;
    assign digest       = dout_reg;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        blk_next    = blk_reg;
        fill_next   = fill_reg;
        msg_next    = msg_reg;
        round_next  = round_reg;
        idx_next    = idx_reg;
        pad_next    = pad_reg;
        mark_next   = mark_reg;
        len_ok_next = len_ok_reg;
        chain_next  = chain_reg;
        v_next      = v_reg;
        dout_next   = dout_reg;
        dval_next   = dval_reg && !digest_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.mode == MODE_DATA)
                    begin
                        blk_next  = {blk_reg[503:0], item.data_byte};
                        fill_next = fill_reg + 6'd1;
                        msg_next  = msg_reg + 61'd1;
                        if (fill_reg == LAST_POS)
                        begin
                            v_next     = chain_reg;
                            state_next = ST_ROUND;
                        end
                    end
                    else
                    begin
                        pad_next   = 1'b1;
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD:
            begin
                blk_next  = {blk_reg[503:0], pad_byte};
                fill_next = fill_reg + 6'd1;
                if (!mark_reg)
                begin
                    mark_next = 1'b1;
                    if (fill_reg < LEN_POS)
                    begin
                        len_ok_next = 1'b1;
                    end
                end
                if (fill_reg == LAST_POS)
                begin
                    v_next     = chain_reg;
                    state_next = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                // Advance the working variables and the schedule window
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                blk_next  = {blk_reg[479:0], w_new};
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end

            ST_FOLD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + v_reg[i];
                end
                if (!pad_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_ok_reg)
                begin
                    idx_next   = 3'd0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    len_ok_next = 1'b1;
                    state_next  = ST_PAD;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    dout_next.digest_word = chain_reg[idx_reg];
                    dout_next.word_index  = idx_reg;
                    dout_next.last_word   = (idx_reg == LAST_WORD);
                    dval_next = 1'b1;
                    idx_next  = idx_reg + 3'd1;
                    if (idx_reg == LAST_WORD)
                    begin
                        // Restart from the initial hash for the next message
                        chain_next  = IV_WORDS;
                        msg_next    = '0;
                        pad_next    = 1'b0;
                        mark_next   = 1'b0;
                        len_ok_next = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            msg_reg    <= '0;
            round_reg  <= '0;
            idx_reg    <= '0;
            pad_reg    <= 1'b0;
            mark_reg   <= 1'b0;
            len_ok_reg <= 1'b0;
            dval_reg   <= 1'b0;
            chain_reg  <= IV_WORDS;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            msg_reg    <= msg_next;
            round_reg  <= round_next;
            idx_reg    <= idx_next;
            pad_reg    <= pad_next;
            mark_reg   <= mark_next;
            len_ok_reg <= len_ok_next;
            dval_reg   <= dval_next;
            chain_reg  <= chain_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        v_reg    <= v_next;
        dout_reg <= dout_next;
    end

    // Round counter only moves inside a compression
    a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_ROUND |-> round_reg == 6'd0)
        else $error("round counter not at zero outside compression");

    // Last round hands over to the fold
    a_round_fold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND && round_reg == LAST_ROUND |=> state_reg == ST_FOLD)
        else $error("compression did not end in fold");

    // Digest words only leave a fully padded message
    a_emit_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> pad_reg && mark_reg && len_ok_reg && fill_reg == 6'd0)
        else $error("emit entered with incomplete padding");

    // A data block fold returns to idle
    a_fold_data: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FOLD && !pad_reg |=> state_reg == ST_IDLE)
        else $error("data block fold did not return to idle");

    // Last-word flag marks the final index and nothing else
    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        dval_reg |-> dout_reg.last_word == (dout_reg.word_index == LAST_WORD))
        else $error("last digest word flag inconsistent with its index");

endmodule
